[rtl/core/dpu_pkg.sv]
// ----------------------------------------------------------------------------
// dpu_pkg
// shared constants, register indexes and helpers for the depth unprojector
// ----------------------------------------------------------------------------
package dpu_pkg;

  // default geometry of the pixel word
  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS_DEF = 16;
  localparam int MAX_COORD_BITS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 7;

  // point word
  localparam int COLOR_W = 8;
  localparam int POS_W   = 32;
  localparam int CONF_W  = 17;

  // arithmetic sizes
  localparam int Q_BITS    = 16;
  localparam int Z_W       = 20;
  localparam int PROD_Z_W  = 33;
  localparam int ND_STAGES = 8;
  localparam int ND_STEPS  = 2;
  localparam int XY_Q_BITS = 32;
  localparam int XY_STAGES = 8;
  localparam int XY_STEPS  = 4;

  localparam logic [CONF_W-1:0]  ONE_Q16    = CONF_W'(65536);
  // largest n that still passes the far test 100*n <= 99*65536
  localparam logic [CONF_W-1:0]  FAR_LIMIT  = CONF_W'(99 * 65536 / 100);
  localparam logic [COLOR_W-1:0] GRAY_LEVEL = COLOR_W'(179);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_DEPTH_GAIN,
    REG_DEPTH_LOW,
    REG_DEPTH_HIGH,
    REG_SUBSAMPLE_STEP
  } reg_idx_t;

  localparam logic [CFG_DATA_W-1:0] FOCAL_RST  = CFG_DATA_W'(16384);
  localparam logic [CFG_DATA_W-1:0] CENTER_RST = CFG_DATA_W'(16384);
  localparam logic [CFG_DATA_W-1:0] GAIN_RST   = CFG_DATA_W'(512);
  localparam logic [CFG_DATA_W-1:0] LOW_RST    = CFG_DATA_W'(0);
  localparam logic [CFG_DATA_W-1:0] HIGH_RST   = CFG_DATA_W'(65535);
  localparam logic [STEP_W-1:0]     STEP_RST   = STEP_W'(1);

  // signed result from magnitude quotient, saturated to 32 bits
  function automatic logic [POS_W-1:0] sat_q(logic [XY_Q_BITS-1:0] q, logic ovf, logic neg);
    logic [POS_W-1:0] r;
    if (neg) begin
      if (ovf || (q[XY_Q_BITS-1] && (|q[XY_Q_BITS-2:0]))) r = {1'b1, {(POS_W-1){1'b0}}};
      else r = POS_W'(0) - POS_W'(q);
    end else begin
      if (ovf || q[XY_Q_BITS-1]) r = {1'b0, {(POS_W-1){1'b1}}};
      else r = POS_W'(q);
    end
    return r;
  endfunction

endpackage

[rtl/core/dpu_if.sv]
// ----------------------------------------------------------------------------
// dpu_if
// pixel, point and configuration channels of the depth unprojector
// ----------------------------------------------------------------------------
interface dpu_pix_if import dpu_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  logic [DEPTH_BITS-1:0] depth_code;
  logic                  color_present;
  logic [COLOR_W-1:0]    red_in;
  logic [COLOR_W-1:0]    green_in;
  logic [COLOR_W-1:0]    blue_in;

  modport source (output valid, pixel_col, pixel_row, depth_code, color_present,
                  red_in, green_in, blue_in, input ready);
  modport sink (input valid, pixel_col, pixel_row, depth_code, color_present,
                red_in, green_in, blue_in, output ready);
endinterface

interface dpu_pt_if import dpu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [POS_W-1:0]   pos_z;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic [CONF_W-1:0]  confidence;

  modport source (output valid, pos_x, pos_y, pos_z, red_out, green_out, blue_out,
                  confidence, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, red_out, green_out, blue_out,
                confidence, output ready);
endinterface

interface dpu_cfg_if import dpu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/depth_pixel_unproject.sv]
// ----------------------------------------------------------------------------
// depth_pixel_unproject
// pinhole unprojection of depth pixels into colored 3d points
// ----------------------------------------------------------------------------
// throughput: one pixel word per clock while the output word is taken; each of
//   the 22 stages holds one word, the depth and position divides run 2 and 4
//   quotient bits per stage
// stalls: every stage has its own valid bit, so empty stages keep filling while
//   the output word waits
// reset: synchronous, clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module depth_pixel_unproject import dpu_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  dpu_pix_if.sink  pix,
  dpu_pt_if.source pt,
  dpu_cfg_if.sink  cfg
);

  // widths that follow from the parameters
  localparam int LH_W  = (DEPTH_BITS < CFG_DATA_W) ? DEPTH_BITS : CFG_DATA_W;
  localparam int MAG_W = (COORD_BITS + 4 > CFG_DATA_W) ? COORD_BITS + 4 : CFG_DATA_W;
  localparam int DX_W  = MAG_W + 1;
  localparam int P_W   = MAG_W + Z_W;
  localparam int HI_W  = P_W - XY_Q_BITS;

  // stage map
  localparam int S_RAW  = 0;
  localparam int S_PREP = 1;
  localparam int S_FIN  = S_PREP + ND_STAGES + 1;
  localparam int S_MUL  = S_FIN + 1;
  localparam int S_MUL2 = S_MUL + 1;
  localparam int S_XY0  = S_MUL2 + 1;
  localparam int S_OUT  = S_XY0 + XY_STAGES;
  localparam int NS     = S_OUT + 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  cp;
    logic [COLOR_W-1:0]    r;
    logic [COLOR_W-1:0]    g;
    logic [COLOR_W-1:0]    b;
  } pix_t;

  typedef struct packed {
    pix_t                  px;
    logic [DEPTH_BITS-1:0] d;
  } raw_t;

  // depth divide and grid remainders, run side by side
  typedef struct packed {
    pix_t                      px;
    logic                      zero;
    logic                      full;
    logic [DEPTH_BITS-1:0]     rem;
    logic [Q_BITS-1:0]         q;
    logic [MAX_COORD_BITS-1:0] cs;
    logic [MAX_COORD_BITS-1:0] rs;
    logic [STEP_W-1:0]         rc;
    logic [STEP_W-1:0]         rr;
  } nd_t;

  typedef struct packed {
    pix_t              px;
    logic [CONF_W-1:0] n;
  } fin_t;

  typedef struct packed {
    logic [PROD_Z_W-1:0] prod;
    logic [MAG_W-1:0]    dxm;
    logic [MAG_W-1:0]    dym;
    logic                dxn;
    logic                dyn;
    logic [COLOR_W-1:0]  r;
    logic [COLOR_W-1:0]  g;
    logic [COLOR_W-1:0]  b;
    logic [CONF_W-1:0]   n;
  } mul_t;

  typedef struct packed {
    logic [P_W-1:0]     px;
    logic [P_W-1:0]     py;
    logic               sx;
    logic               sy;
    logic [Z_W-1:0]     z;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic [CONF_W-1:0]  n;
  } m2_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] rx;
    logic [CFG_DATA_W-1:0] ry;
    logic [XY_Q_BITS-1:0]  nx;
    logic [XY_Q_BITS-1:0]  ny;
    logic [XY_Q_BITS-1:0]  qx;
    logic [XY_Q_BITS-1:0]  qy;
    logic                  ox;
    logic                  oy;
    logic                  sx;
    logic                  sy;
    logic [Z_W-1:0]        z;
    logic [COLOR_W-1:0]    r;
    logic [COLOR_W-1:0]    g;
    logic [COLOR_W-1:0]    b;
    logic [CONF_W-1:0]     n;
  } xy_t;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic [CONF_W-1:0]  n;
  } out_t;

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] focal_x, focal_y, center_x, center_y;
  logic [CFG_DATA_W-1:0] depth_gain, depth_low, depth_high;
  logic [STEP_W-1:0]     subsample_step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x        <= FOCAL_RST;
      focal_y        <= FOCAL_RST;
      center_x       <= CENTER_RST;
      center_y       <= CENTER_RST;
      depth_gain     <= GAIN_RST;
      depth_low      <= LOW_RST;
      depth_high     <= HIGH_RST;
      subsample_step <= STEP_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_FOCAL_X:        focal_x        <= cfg.data;
        REG_FOCAL_Y:        focal_y        <= cfg.data;
        REG_CENTER_X:       center_x       <= cfg.data;
        REG_CENTER_Y:       center_y       <= cfg.data;
        REG_DEPTH_GAIN:     depth_gain     <= cfg.data;
        REG_DEPTH_LOW:      depth_low      <= cfg.data;
        REG_DEPTH_HIGH:     depth_high     <= cfg.data;
        REG_SUBSAMPLE_STEP: subsample_step <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // derived settings, refreshed every cycle; user must change registers only while idle, unchecked
  logic [DEPTH_BITS-1:0] lo_c, hi_c, lo_r, span_r;
  logic [CFG_DATA_W-1:0] fx_r, fy_r;
  logic [STEP_W-1:0]     step_r;

  assign lo_c = DEPTH_BITS'(depth_low[LH_W-1:0]);
  assign hi_c = DEPTH_BITS'(depth_high[LH_W-1:0]);

  always_ff @(posedge clk) begin
    lo_r   <= lo_c;
    // empty or inverted range counts as one code
    span_r <= (hi_c > lo_c) ? hi_c - lo_c : DEPTH_BITS'(1);
    // a zero focal length or grid step acts as one
    fx_r   <= (focal_x == '0) ? CFG_DATA_W'(1) : focal_x;
    fy_r   <= (focal_y == '0) ? CFG_DATA_W'(1) : focal_y;
    step_r <= (subsample_step == '0) ? STEP_W'(1) : subsample_step;
  end

  // --------------------------------------------------------------------------
  // stage handshake: a stage takes a word when empty or when it drains
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld;
  logic [NS-1:0] vin;
  logic [NS:0]   rdy;
  logic          keep;

  assign rdy[NS] = pt.ready;

  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end

  always_comb begin
    vin[S_RAW] = pix.valid;
    for (int i = 1; i < NS; i++) vin[i] = vld[i-1];
    // off-grid and far pixels turn into bubbles here
    vin[S_FIN] = vld[S_FIN-1] && keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) vld[i] <= vin[i];
      end
    end
  end

  assign pix.ready = rdy[S_RAW];

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  raw_t raw;

  always_ff @(posedge clk) begin
    if (rdy[S_RAW]) begin
      raw.px.col <= pix.pixel_col;
      raw.px.row <= pix.pixel_row;
      raw.px.cp  <= pix.color_present;
      raw.px.r   <= pix.red_in;
      raw.px.g   <= pix.green_in;
      raw.px.b   <= pix.blue_in;
      raw.d      <= pix.depth_code;
    end
  end

  // --------------------------------------------------------------------------
  // depth normalize: n = floor((d - lo) * 2^16 / span), done as a restoring
  // divide of (d - lo) against span, two quotient bits per stage; the grid
  // remainders col % step and row % step ride along, two bits per stage
  // --------------------------------------------------------------------------
  nd_t nd      [0:ND_STAGES];
  nd_t nd_next [0:ND_STAGES];

  always_comb begin
    logic [DEPTH_BITS:0] diff;
    diff = {1'b0, raw.d} - {1'b0, lo_r};
    nd_next[0].px   = raw.px;
    // at or below the low code n is zero, at or beyond the span n is one
    nd_next[0].zero = (raw.d <= lo_r);
    nd_next[0].full = (raw.d > lo_r) && (diff[DEPTH_BITS-1:0] >= span_r);
    nd_next[0].rem  = diff[DEPTH_BITS-1:0];
    nd_next[0].q    = '0;
    nd_next[0].cs   = MAX_COORD_BITS'(raw.px.col);
    nd_next[0].rs   = MAX_COORD_BITS'(raw.px.row);
    nd_next[0].rc   = '0;
    nd_next[0].rr   = '0;
  end

  for (genvar k = 1; k <= ND_STAGES; k++) begin : g_nd
    always_comb begin
      logic [DEPTH_BITS:0] t;
      logic [STEP_W:0]     tc;
      logic [STEP_W:0]     tr;
      nd_t                 s;
      s = nd[k-1];
      for (int j = 0; j < ND_STEPS; j++) begin
        t = {s.rem, 1'b0};
        if (t >= {1'b0, span_r}) begin
          s.rem = DEPTH_BITS'(t - {1'b0, span_r});
          s.q   = {s.q[Q_BITS-2:0], 1'b1};
        end else begin
          s.rem = t[DEPTH_BITS-1:0];
          s.q   = {s.q[Q_BITS-2:0], 1'b0};
        end
        tc = {s.rc, s.cs[MAX_COORD_BITS-1]};
        if (tc >= {1'b0, step_r}) s.rc = STEP_W'(tc - {1'b0, step_r});
        else s.rc = tc[STEP_W-1:0];
        s.cs = {s.cs[MAX_COORD_BITS-2:0], 1'b0};
        tr = {s.rr, s.rs[MAX_COORD_BITS-1]};
        if (tr >= {1'b0, step_r}) s.rr = STEP_W'(tr - {1'b0, step_r});
        else s.rr = tr[STEP_W-1:0];
        s.rs = {s.rs[MAX_COORD_BITS-2:0], 1'b0};
      end
      nd_next[k] = s;
    end
  end

  for (genvar k = 0; k <= ND_STAGES; k++) begin : g_nd_reg
    always_ff @(posedge clk) begin
      if (rdy[S_PREP+k]) nd[k] <= nd_next[k];
    end
  end

  // --------------------------------------------------------------------------
  // confidence, grid and far filter
  // --------------------------------------------------------------------------
  fin_t fin, fin_next;

  always_comb begin
    fin_next.px = nd[ND_STAGES].px;
    if (nd[ND_STAGES].zero)      fin_next.n = '0;
    else if (nd[ND_STAGES].full) fin_next.n = ONE_Q16;
    else                         fin_next.n = CONF_W'(nd[ND_STAGES].q);
    keep = (nd[ND_STAGES].rc == '0) && (nd[ND_STAGES].rr == '0) &&
           (fin_next.n <= FAR_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rdy[S_FIN]) fin <= fin_next;
  end

  // --------------------------------------------------------------------------
  // z product, image plane offsets in Q12.4, color pick
  // --------------------------------------------------------------------------
  mul_t mul, mul_next;

  always_comb begin
    logic [CONF_W-1:0] inv;
    logic [DX_W-1:0]   dxs;
    logic [DX_W-1:0]   dys;
    logic [DX_W-1:0]   dxneg;
    logic [DX_W-1:0]   dyneg;
    inv   = ONE_Q16 - fin.n;
    dxs   = DX_W'({fin.px.col, 4'b0000}) - DX_W'(center_x);
    dys   = DX_W'(center_y) - DX_W'({fin.px.row, 4'b0000});
    dxneg = DX_W'(0) - dxs;
    dyneg = DX_W'(0) - dys;
    mul_next.prod = PROD_Z_W'(inv) * PROD_Z_W'(depth_gain);
    mul_next.dxn  = dxs[MAG_W];
    mul_next.dyn  = dys[MAG_W];
    mul_next.dxm  = dxs[MAG_W] ? dxneg[MAG_W-1:0] : dxs[MAG_W-1:0];
    mul_next.dym  = dys[MAG_W] ? dyneg[MAG_W-1:0] : dys[MAG_W-1:0];
    mul_next.r    = fin.px.cp ? fin.px.r : GRAY_LEVEL;
    mul_next.g    = fin.px.cp ? fin.px.g : GRAY_LEVEL;
    mul_next.b    = fin.px.cp ? fin.px.b : GRAY_LEVEL;
    mul_next.n    = fin.n;
  end

  always_ff @(posedge clk) begin
    if (rdy[S_MUL]) mul <= mul_next;
  end

  // --------------------------------------------------------------------------
  // offset magnitude times z
  // --------------------------------------------------------------------------
  m2_t m2, m2_next;

  always_comb begin
    logic [Z_W-1:0] z;
    z = mul.prod[12 +: Z_W];
    m2_next.z  = z;
    m2_next.px = P_W'(mul.dxm) * P_W'(z);
    m2_next.py = P_W'(mul.dym) * P_W'(z);
    m2_next.sx = mul.dxn;
    m2_next.sy = mul.dyn;
    m2_next.r  = mul.r;
    m2_next.g  = mul.g;
    m2_next.b  = mul.b;
    m2_next.n  = mul.n;
  end

  always_ff @(posedge clk) begin
    if (rdy[S_MUL2]) m2 <= m2_next;
  end

  // --------------------------------------------------------------------------
  // divide by focal length: 32 quotient bits, four per stage; the bits from 2^32
  // up are checked up front and, when they reach the focal length, force saturation
  // --------------------------------------------------------------------------
  xy_t xy      [0:XY_STAGES-1];
  xy_t xy_src  [0:XY_STAGES-1];
  xy_t xy_next [0:XY_STAGES-1];

  always_comb begin
    logic [HI_W-1:0] hx;
    logic [HI_W-1:0] hy;
    hx = m2.px[P_W-1:XY_Q_BITS];
    hy = m2.py[P_W-1:XY_Q_BITS];
    xy_src[0].ox = (CFG_DATA_W'(hx) >= fx_r);
    xy_src[0].oy = (CFG_DATA_W'(hy) >= fy_r);
    xy_src[0].rx = xy_src[0].ox ? '0 : CFG_DATA_W'(hx);
    xy_src[0].ry = xy_src[0].oy ? '0 : CFG_DATA_W'(hy);
    xy_src[0].nx = m2.px[XY_Q_BITS-1:0];
    xy_src[0].ny = m2.py[XY_Q_BITS-1:0];
    xy_src[0].qx = '0;
    xy_src[0].qy = '0;
    xy_src[0].sx = m2.sx;
    xy_src[0].sy = m2.sy;
    xy_src[0].z  = m2.z;
    xy_src[0].r  = m2.r;
    xy_src[0].g  = m2.g;
    xy_src[0].b  = m2.b;
    xy_src[0].n  = m2.n;
  end

  for (genvar k = 1; k < XY_STAGES; k++) begin : g_xy_src
    assign xy_src[k] = xy[k-1];
  end

  for (genvar k = 0; k < XY_STAGES; k++) begin : g_xy
    always_comb begin
      logic [CFG_DATA_W:0] tx;
      logic [CFG_DATA_W:0] ty;
      xy_t                 s;
      s = xy_src[k];
      for (int j = 0; j < XY_STEPS; j++) begin
        tx = {s.rx, s.nx[XY_Q_BITS-1]};
        if (tx >= {1'b0, fx_r}) begin
          s.rx = CFG_DATA_W'(tx - {1'b0, fx_r});
          s.qx = {s.qx[XY_Q_BITS-2:0], 1'b1};
        end else begin
          s.rx = tx[CFG_DATA_W-1:0];
          s.qx = {s.qx[XY_Q_BITS-2:0], 1'b0};
        end
        s.nx = {s.nx[XY_Q_BITS-2:0], 1'b0};
        ty = {s.ry, s.ny[XY_Q_BITS-1]};
        if (ty >= {1'b0, fy_r}) begin
          s.ry = CFG_DATA_W'(ty - {1'b0, fy_r});
          s.qy = {s.qy[XY_Q_BITS-2:0], 1'b1};
        end else begin
          s.ry = ty[CFG_DATA_W-1:0];
          s.qy = {s.qy[XY_Q_BITS-2:0], 1'b0};
        end
        s.ny = {s.ny[XY_Q_BITS-2:0], 1'b0};
      end
      xy_next[k] = s;
    end

    always_ff @(posedge clk) begin
      if (rdy[S_XY0+k]) xy[k] <= xy_next[k];
    end
  end

  // --------------------------------------------------------------------------
  // sign, saturation and the output register
  // --------------------------------------------------------------------------
  out_t res, res_next;

  always_comb begin
    res_next.x = sat_q(xy[XY_STAGES-1].qx, xy[XY_STAGES-1].ox, xy[XY_STAGES-1].sx);
    res_next.y = sat_q(xy[XY_STAGES-1].qy, xy[XY_STAGES-1].oy, xy[XY_STAGES-1].sy);
    res_next.z = POS_W'(0) - POS_W'(xy[XY_STAGES-1].z);
    res_next.r = xy[XY_STAGES-1].r;
    res_next.g = xy[XY_STAGES-1].g;
    res_next.b = xy[XY_STAGES-1].b;
    res_next.n = xy[XY_STAGES-1].n;
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) res <= res_next;
  end

  assign pt.valid      = vld[S_OUT];
  assign pt.pos_x      = res.x;
  assign pt.pos_y      = res.y;
  assign pt.pos_z      = res.z;
  assign pt.red_out    = res.r;
  assign pt.green_out  = res.g;
  assign pt.blue_out   = res.b;
  assign pt.confidence = res.n;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // depth is never in front of the camera
  a_z_nonpos: assert property (@(posedge clk) disable iff (rst)
    pt.valid |-> (pt.pos_z[POS_W-1] || (pt.pos_z == '0)))
    else $error("point with positive z");

  // far pixels never leave the block
  a_far_drop: assert property (@(posedge clk) disable iff (rst)
    pt.valid |-> (pt.confidence <= FAR_LIMIT))
    else $error("far pixel passed the filter");

  // an empty input stage always takes a word, whatever the output does
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !vld[S_RAW] |-> pix.ready)
    else $error("input stalled while empty");

endmodule

[bench/depth_pixel_unproject_tb.sv]
// ----------------------------------------------------------------------------
// depth_pixel_unproject_tb
// streams depth pixels through the unprojector and checks every point word
// against a bit-exact predictor, under random idling, a long output stall and
// several register settings including the extremes
// ----------------------------------------------------------------------------
module depth_pixel_unproject_tb;
  import dpu_pkg::*;

  typedef struct {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic [CONF_W-1:0]  conf;
  } point_t;

  // register copy used by the predictor
  logic [15:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [15:0] gain_r, low_r, high_r;
  logic [6:0]  step_r;

  int unsigned errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // (num * z) / den truncated toward zero, saturated to 32 bits signed
  function automatic logic [31:0] scaled_coord(longint num, longint unsigned z,
                                               longint unsigned den);
    longint unsigned mag, q;
    bit neg;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    if (den == 0) den = 1;
    q = (mag * z) / den;
    if (neg) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return 32'(-longint'(q));
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return 32'(q);
  endfunction

  // returns 1 and the point when the pixel yields one
  function automatic bit unproject(input logic [11:0] col, row, input logic [15:0] d,
                                   input logic cp, input logic [7:0] ri, gi, bi,
                                   output point_t p);
    longint span, diff, n;
    longint unsigned z, step;
    step = (step_r == 0) ? 1 : step_r;
    if ((col % step) != 0 || (row % step) != 0) return 0;
    span = longint'(high_r) - longint'(low_r);
    if (span <= 0) span = 1;
    diff = longint'(d) - longint'(low_r);
    if (diff <= 0) n = 0;
    else begin
      n = (diff * 65536) / span;
      if (n > 65536) n = 65536;
    end
    if (n * 100 > 99 * 65536) return 0;
    z = ((65536 - n) * gain_r) >> 12;
    p.x = scaled_coord(longint'(col) * 16 - longint'(center_x_r), z, focal_x_r);
    p.y = scaled_coord(longint'(center_y_r) - longint'(row) * 16, z, focal_y_r);
    p.z = 32'(-longint'(z));
    p.r = cp ? ri : GRAY_LEVEL;
    p.g = cp ? gi : GRAY_LEVEL;
    p.b = cp ? bi : GRAY_LEVEL;
    p.conf = CONF_W'(n);
    return 1;
  endfunction

  class point_board;
    point_t pending[$];
    int unsigned checked;

    function void note_pixel(logic [11:0] col, row, logic [15:0] d, logic cp,
                             logic [7:0] ri, gi, bi);
      point_t p;
      if (unproject(col, row, d, cp, ri, gi, bi, p)) pending.push_back(p);
    endfunction

    task check_point(point_t got);
      point_t e;
      if (pending.size() == 0) begin
        report("unexpected point word", 1, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.x !== e.x) report("pos_x", $signed(got.x), $signed(e.x));
      if (got.y !== e.y) report("pos_y", $signed(got.y), $signed(e.y));
      if (got.z !== e.z) report("pos_z", $signed(got.z), $signed(e.z));
      if (got.r !== e.r) report("red_out", got.r, e.r);
      if (got.g !== e.g) report("green_out", got.g, e.g);
      if (got.b !== e.b) report("blue_out", got.b, e.b);
      if (got.conf !== e.conf) report("confidence", got.conf, e.conf);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  always #10 clk = ~clk;

  dpu_pix_if pix ();
  dpu_pt_if  pt ();
  dpu_cfg_if cfg ();

  depth_pixel_unproject u_top (.clk(clk), .rst(rst), .pix(pix), .pt(pt), .cfg(cfg));

  point_board board = new();

  // idle percentages for sender and receiver, plus the long output hold-off
  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_out;
  int unsigned pixels_sent;
  longint unsigned cycles;

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout waiting for point words");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random ready at the falling edge, check words at the rising edge
  always @(negedge clk) begin
    if (rst) pt.ready <= 1'b0;
    else pt.ready <= !hold_out && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && pt.valid && pt.ready)
      board.check_point('{pt.pos_x, pt.pos_y, pt.pos_z, pt.red_out, pt.green_out,
                          pt.blue_out, pt.confidence});
  end

  // one register write over the configuration channel; predictor copy follows
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_FOCAL_X:        focal_x_r  = val;
      REG_FOCAL_Y:        focal_y_r  = val;
      REG_CENTER_X:       center_x_r = val;
      REG_CENTER_Y:       center_y_r = val;
      REG_DEPTH_GAIN:     gain_r     = val;
      REG_DEPTH_LOW:      low_r      = val;
      REG_DEPTH_HIGH:     high_r     = val;
      REG_SUBSAMPLE_STEP: step_r     = val[6:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(logic [15:0] fx, fy, cx, cy, g, lo, hi, st);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_DEPTH_GAIN, g);
    write_reg(REG_DEPTH_LOW, lo);
    write_reg(REG_DEPTH_HIGH, hi);
    write_reg(REG_SUBSAMPLE_STEP, st);
    cfg.valid <= 1'b0;
  endtask

  // offer one pixel word, with a random idle gap first; called at a falling edge
  task automatic send_pixel(logic [11:0] col, row, logic [15:0] d, logic cp,
                            logic [7:0] ri, gi, bi);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_col <= col;
    pix.pixel_row <= row;
    pix.depth_code <= d;
    pix.color_present <= cp;
    pix.red_in <= ri;
    pix.green_in <= gi;
    pix.blue_in <= bi;
    do @(posedge clk); while (!pix.ready);
    board.note_pixel(col, row, d, cp, ri, gi, bi);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic rand_pixel();
    logic [11:0] col, row;
    logic [15:0] d;
    int unsigned st;
    st = (step_r == 0) ? 1 : step_r;
    // mostly pixels on the grid so they reach the arithmetic
    if ($urandom_range(3) != 0) begin
      col = 12'(st * $urandom_range(4095 / st));
      row = 12'(st * $urandom_range(4095 / st));
    end else begin
      col = 12'($urandom);
      row = 12'($urandom);
    end
    case ($urandom_range(3))
      0: d = 16'($urandom);
      1: d = low_r + 16'($urandom_range(15)) - 16'd8;
      default: d = 16'($urandom_range(int'(low_r), int'(high_r)));
    endcase
    send_pixel(col, row, d, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    pix.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  int unsigned ph;

  initial begin
    pix.valid = 0; pix.pixel_col = 0; pix.pixel_row = 0; pix.depth_code = 0;
    pix.color_present = 0; pix.red_in = 0; pix.green_in = 0; pix.blue_in = 0;
    cfg.valid = 0; cfg.index = REG_FOCAL_X; cfg.data = 0;
    hold_out = 0; pixels_sent = 0;
    send_idle_pct = 15; recv_idle_pct = 65;
    focal_x_r = FOCAL_RST; focal_y_r = FOCAL_RST;
    center_x_r = CENTER_RST; center_y_r = CENTER_RST;
    gain_r = GAIN_RST; low_r = LOW_RST; high_r = HIGH_RST; step_r = STEP_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset registers, field extremes, color and gray, far cut
    send_pixel(0, 0, 0, 0, 0, 0, 0);
    send_pixel(4095, 4095, 16'hffff, 1, 8'hff, 8'hff, 8'hff);
    send_pixel(1024, 1024, 16'd100, 1, 8'h55, 8'haa, 8'h0f);
    send_pixel(4095, 0, 16'd64880, 0, 8'hff, 0, 8'hff);
    send_pixel(0, 4095, 16'd64881, 1, 0, 8'hff, 0);
    drain();
    // zero focal, zero step, zero gain
    write_all(0, 0, 0, 16'hffff, 0, 0, 16'hffff, 0);
    send_pixel(7, 9, 16'd1000, 1, 1, 2, 3);
    send_pixel(4095, 4095, 0, 0, 0, 0, 0);
    drain();
    // inverted and equal ranges, max gain and focal 1 to hit saturation
    write_all(1, 1, 0, 16'hffff, 16'hffff, 16'd5000, 16'd4000, 3);
    send_pixel(4095, 4095, 16'd4999, 1, 9, 8, 7);
    send_pixel(3, 6, 16'd5000, 0, 0, 0, 0);
    send_pixel(4, 6, 16'd1, 0, 0, 0, 0);
    send_pixel(4095, 0, 16'd0, 1, 8'h80, 8'h40, 8'h20);
    drain();
    write_all(16'hffff, 16'hffff, 16'hffff, 0, 16'h0100, 16'd7, 16'd7, 7'd127);
    send_pixel(0, 0, 16'd6, 1, 1, 1, 1);
    send_pixel(0, 0, 16'd7, 1, 1, 1, 1);
    send_pixel(127, 254, 16'd8, 0, 0, 0, 0);
    drain();
    write_all(16'd64, 16'd64, 16'd32768, 16'd32768, 16'd4096, 0, 16'hffff, 64);
    send_pixel(64, 128, 16'd30000, 1, 3, 4, 5);
    drain();

    // random phases, each with its own register setting and one of three idle patterns
    for (ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 15; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 5)
        write_all(FOCAL_RST, FOCAL_RST, CENTER_RST, CENTER_RST, GAIN_RST,
                  LOW_RST, HIGH_RST, STEP_RST);
      else
        write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom),
                  16'($urandom_range(20000)), 16'($urandom_range(65535, 30000)),
                  16'($urandom_range(ph == 3 ? 2 : 4, 1)));
      // long output hold-off while pixels keep being offered
      if (ph == 2) fork
        begin
          hold_out = 1;
          repeat (200) @(negedge clk);
          hold_out = 0;
        end
      join_none
      repeat (320) rand_pixel();
      drain();
    end

    $display("covered %0d pixel words, %0d point words checked over 11 register settings",
             pixels_sent, board.checked);
    $display("including zero focal, step and gain, inverted range and a long output stall");
    if (errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[depth_pixel_unproject.f]
rtl/core/dpu_pkg.sv
rtl/core/dpu_if.sv
rtl/core/depth_pixel_unproject.sv
bench/depth_pixel_unproject_tb.sv
